// ----- hw/rtl/height_map_cell_ema_update_macros.svh -----
// ----------------------------------------------------------------------------
// Height map cell EMA update: assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_MAP_CELL_EMA_UPDATE_MACROS_SVH
`define HEIGHT_MAP_CELL_EMA_UPDATE_MACROS_SVH

// same-cycle implication
`define HMCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HMCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hmce_pkg.sv -----
// ----------------------------------------------------------------------------
// hmce_pkg
// Types, constants and the EMA blend shared by the height map cell update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmce_pkg;

  localparam int GRID_SIDE = 256;
  localparam int GRID_BITS = $clog2(GRID_SIDE);
  localparam int ADDR_W    = 2 * GRID_BITS;

  localparam logic [7:0] ALPHA_MIN = 8'd26;
  localparam logic [7:0] ALPHA_MAX = 8'd230;

  localparam logic [1:0] OP_PLAIN = 2'd0;
  localparam logic [1:0] OP_LASER = 2'd1;
  localparam logic [1:0] OP_COLOR = 2'd2;

  localparam logic [1:0] REG_ALPHA      = 2'd0;
  localparam logic [1:0] REG_ORIGIN_X   = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd2;
  localparam logic [1:0] REG_CELL_SHIFT = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        intensity_in;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
  } point_t;

  typedef struct packed {
    logic               in_map;
    logic               first_hit;
    logic [7:0]         cell_row;
    logic [7:0]         cell_col;
    logic signed [15:0] height_avg;
    logic signed [15:0] height_low;
    logic signed [15:0] height_high;
    logic [15:0]        hit_count;
    logic [15:0]        intensity_avg;
    logic [7:0]         red_avg;
    logic [7:0]         green_avg;
    logic [7:0]         blue_avg;
  } result_t;

  // one memory word per cell
  typedef struct packed {
    logic               valid;
    logic signed [15:0] height;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic [15:0]        count;
    logic [15:0]        intensity;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } cell_t;

  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic rd_cell;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } stat_t;

  // floor((cur*(256-a) + nw*a + 128) / 256); result lies between cur and nw
  function automatic logic signed [16:0] ema(input logic signed [16:0] cur,
                                             input logic signed [16:0] nw,
                                             input logic [7:0] a);
    logic signed [9:0]  wa;
    logic signed [9:0]  wc;
    logic signed [27:0] s;
    wa = signed'({2'b00, a});
    wc = 10'sd256 - wa;
    s  = cur * wc + nw * wa + 28'sd128;
    return s[24:8];
  endfunction

endpackage

// ----- hw/rtl/height_map_cell_ema_update.sv -----
// ----------------------------------------------------------------------------
// height_map_cell_ema_update
// Grid height map: maps a point to its cell and updates height EMA, min/max,
// hit count, intensity and colour in a 65536-entry cell memory.
//
//   channel | signals                                  | word
//   in      | in_valid, in_ready, in_data              | hmce_pkg::point_t
//   out     | out_valid, out_ready, out_data           | hmce_pkg::result_t
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// Each point word passes an index/read state (S_ADDR) and a read-modify-write
// state (S_UPD) on the single-port cell memory.
// The result word is registered in the update state; the next input
// word is taken in the update cycle if the output register is free.
// After reset the memory is cleared, one cell per cycle, with in_ready low.
// cfg writes are taken at any time outside reset.
// A stalled output holds the update cycle until out_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module height_map_cell_ema_update (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hmce_pkg::point_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hmce_pkg::result_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data
);
  import hmce_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = !rst;

  hmce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hmce_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/hmce_ctrl.sv -----
// ----------------------------------------------------------------------------
// hmce_ctrl
// Sequencer: memory clear after reset, then address / update per point word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmce_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  hmce_pkg::stat_t stat,
  output hmce_pkg::cmd_t  cmd
);
  import hmce_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_ADDR, S_UPD} state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    in_ready    = !rst && ((state == S_IDLE) || (state == S_UPD && out_free));
    cmd.clr_wr  = (state == S_CLEAR);
    cmd.load_in = in_valid && in_ready;
    cmd.rd_cell = (state == S_ADDR);
    cmd.upd     = (state == S_UPD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.upd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (stat.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_ADDR;
        end
        S_ADDR: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (out_free) state <= in_valid ? S_ADDR : S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

// ----- hw/rtl/hmce_dp.sv -----
// ----------------------------------------------------------------------------
// hmce_dp
// Config registers, cell index, cell memory and the blend/min/max update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmce_dp (
  input  logic             clk,
  input  logic             rst,
  input  hmce_pkg::cmd_t   cmd,
  output hmce_pkg::stat_t  stat,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [23:0]      cfg_data,
  input  hmce_pkg::point_t in_data,
  output hmce_pkg::result_t out_data
);
  import hmce_pkg::*;

  logic [7:0]         alpha;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic [3:0]         cell_shift;

  point_t               pt;
  cell_t                mem [2**ADDR_W];
  cell_t                rd_q;
  logic [ADDR_W-1:0]    clr_addr;
  logic [GRID_BITS-1:0] row_q;
  logic [GRID_BITS-1:0] col_q;
  logic                 map_q;

  logic signed [24:0]   dx;
  logic signed [24:0]   dy;
  logic [23:0]          row_full;
  logic [23:0]          col_full;
  logic                 hit;

  logic [7:0]           a_cl;
  logic                 first;
  logic signed [16:0]   h_bl;
  logic signed [16:0]   i_bl;
  logic signed [16:0]   r_bl;
  logic signed [16:0]   g_bl;
  logic signed [16:0]   b_bl;
  cell_t                nxt;
  result_t              res;
  logic [23:0]          row_ext;
  logic [23:0]          col_ext;

  assign stat.clr_last = &clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha      <= 8'd128;
      origin_x   <= '0;
      origin_y   <= '0;
      cell_shift <= 4'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA:      alpha      <= cfg_data[7:0];
        REG_ORIGIN_X:   origin_x   <= cfg_data;
        REG_ORIGIN_Y:   origin_y   <= cfg_data;
        REG_CELL_SHIFT: cell_shift <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) pt <= in_data;
  end

  // cell index
  always_comb begin
    dx       = {pt.pos_x[23], pt.pos_x} - {origin_x[23], origin_x};
    dy       = {pt.pos_y[23], pt.pos_y} - {origin_y[23], origin_y};
    row_full = dx[23:0] >> cell_shift;
    col_full = dy[23:0] >> cell_shift;
    hit      = !dx[24] && !dy[24] && (row_full[23:GRID_BITS] == '0)
               && (col_full[23:GRID_BITS] == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_cell) begin
      row_q <= row_full[GRID_BITS-1:0];
      col_q <= col_full[GRID_BITS-1:0];
      map_q <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.upd && map_q) begin
      mem[{row_q, col_q}] <= nxt;
    end
    if (cmd.rd_cell) begin
      rd_q <= mem[{row_full[GRID_BITS-1:0], col_full[GRID_BITS-1:0]}];
    end
  end

  // cell update
  always_comb begin
    if (alpha < ALPHA_MIN) begin
      a_cl = ALPHA_MIN;
    end else if (alpha > ALPHA_MAX) begin
      a_cl = ALPHA_MAX;
    end else begin
      a_cl = alpha;
    end
    first = !rd_q.valid;
    h_bl  = ema({rd_q.height[15], rd_q.height}, {pt.pos_z[15], pt.pos_z}, a_cl);
    i_bl  = ema({1'b0, rd_q.intensity}, {1'b0, pt.intensity_in}, a_cl);
    r_bl  = ema({9'd0, rd_q.red}, {9'd0, pt.red_in}, a_cl);
    g_bl  = ema({9'd0, rd_q.green}, {9'd0, pt.green_in}, a_cl);
    b_bl  = ema({9'd0, rd_q.blue}, {9'd0, pt.blue_in}, a_cl);

    nxt       = rd_q;
    nxt.valid = 1'b1;
    if (first) begin
      nxt.height = pt.pos_z;
      nxt.low    = pt.pos_z;
      nxt.high   = pt.pos_z;
      case (pt.op)
        OP_PLAIN: nxt.count     = 16'd1;
        OP_LASER: nxt.intensity = pt.intensity_in;
        OP_COLOR: begin
          nxt.red   = pt.red_in;
          nxt.green = pt.green_in;
          nxt.blue  = pt.blue_in;
        end
        default: ;
      endcase
    end else begin
      nxt.height = h_bl[15:0];
      if (pt.pos_z < rd_q.low)  nxt.low  = pt.pos_z;
      if (pt.pos_z > rd_q.high) nxt.high = pt.pos_z;
      case (pt.op)
        OP_PLAIN: begin
          if (rd_q.count != 16'hFFFF) nxt.count = rd_q.count + 16'd1;
        end
        OP_LASER: nxt.intensity = i_bl[15:0];
        OP_COLOR: begin
          nxt.red   = r_bl[7:0];
          nxt.green = g_bl[7:0];
          nxt.blue  = b_bl[7:0];
        end
        default: ;
      endcase
    end

    row_ext = 24'(row_q);
    col_ext = 24'(col_q);
    res     = '0;
    if (map_q) begin
      res.in_map        = 1'b1;
      res.first_hit     = first;
      res.cell_row      = row_ext[7:0];
      res.cell_col      = col_ext[7:0];
      res.height_avg    = nxt.height;
      res.height_low    = nxt.low;
      res.height_high   = nxt.high;
      res.hit_count     = nxt.count;
      res.intensity_avg = nxt.intensity;
      res.red_avg       = nxt.red;
      res.green_avg     = nxt.green;
      res.blue_avg      = nxt.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) out_data <= res;
  end

endmodule

// ----- hw/rtl/hmce_chk.sv -----
// ----------------------------------------------------------------------------
// hmce_chk
// Port-level checks for the height map cell update, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "height_map_cell_ema_update_macros.svh"

module hmce_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input hmce_pkg::result_t out_data
);
  import hmce_pkg::*;

  `HMCE_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready, "input word taken twice in a row")
  `HMCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `HMCE_ASSERT_NOW(a_first_in_map, out_valid && out_data.first_hit, out_data.in_map, "first hit outside map")
  `HMCE_ASSERT_NOW(a_miss_zero, out_valid && !out_data.in_map, out_data == '0, "off-map result not zero")
  `HMCE_ASSERT_NOW(a_avg_bounds, out_valid && out_data.in_map, (out_data.height_low <= out_data.height_avg) && (out_data.height_avg <= out_data.height_high), "height outside min/max")

endmodule

bind height_map_cell_ema_update hmce_chk u_chk (.*);
